/* hdl/nmea_pkg.sv */
// Shared types and constants for the NMEA GGA/GSA field extractor.
// No dependencies; used by nmea_gga_gsa_field_extractor and the testbench.
`timescale 1ns / 1ps

package nmea_pkg;

  // ASCII characters that steer the parser
  localparam logic [7:0] ChDollar = 8'h24;
  localparam logic [7:0] ChStar   = 8'h2A;
  localparam logic [7:0] ChComma  = 8'h2C;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChG      = 8'h47;
  localparam logic [7:0] ChP      = 8'h50;
  localparam logic [7:0] ChS      = 8'h53;
  localparam logic [7:0] ChA      = 8'h41;

  // Header match codes
  localparam logic [1:0] HmSearch = 2'd0;
  localparam logic [1:0] HmGga    = 2'd1;
  localparam logic [1:0] HmGsa    = 2'd2;
  localparam logic [1:0] HmNone   = 2'd3;

  // Result kinds
  localparam logic KindChar = 1'b0;
  localparam logic KindSum  = 1'b1;

  // Sentence types on the result
  localparam logic TypeGga = 1'b0;
  localparam logic TypeGsa = 1'b1;

  localparam int unsigned FieldMax = 31;

  // One result request
  typedef struct packed {
    logic [7:0] checksum;
    logic [7:0] char_value;
    logic [4:0] char_index;
    logic [4:0] field_number;
    logic       sentence_type;
    logic       kind;
  } result_t;

  // Fields of interest per sentence type
  function automatic logic field_wanted(input logic [1:0] hm, input logic [4:0] f);
    logic w;
    w = 1'b0;
    if (hm == HmGga) begin
      w = (f >= 5'd1 && f <= 5'd5) || f == 5'd9 || f == 5'd10;
    end else if (hm == HmGsa) begin
      w = (f >= 5'd3 && f <= 5'd10);
    end
    return w;
  endfunction

endpackage

/* hdl/nmea_gga_gsa_field_extractor.sv */
// NMEA GGA/GSA field extractor: stream in characters, stream out field characters
// and checksums. Depends on nmea_pkg.
`timescale 1ns / 1ps

// Accepts one NMEA character per clock and returns at most one result per
// character, carried through the input register, then the result register.
// Throughput is one character every cycle; the only limit is the single result
// register, so s_axis_tready drops only while a result waits and m_axis_tready is
// low. '$' opens a sentence; "GPGGA" sentences yield every character of fields
// 1-5, 9 and 10, "GPGSA" sentences yield fields 3-10, each tagged with field
// number and position within the field. At '*' the XOR of the bytes after '$'
// is reported (not checked). CR, LF or '*' close a sentence; unknown headers
// produce nothing. A sentence longer than MAX_SENTENCE_LEN bytes is dropped at
// that length.
module nmea_gga_gsa_field_extractor #(
  parameter int unsigned MAX_SENTENCE_LEN = 256,
  parameter int unsigned MAX_FIELD_CHARS  = 20
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_char
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [4:0] field_number, [9:5] char_index,
                                      // [17:10] char_value, [25:18] checksum, rest 0
  output logic [1:0]  m_axis_tuser    // [0] kind, [1] sentence_type
);

  localparam int unsigned PosW = $clog2(MAX_SENTENCE_LEN + 1);
  localparam int unsigned LimRaw = (MAX_FIELD_CHARS > 1) ? MAX_FIELD_CHARS - 1 : 0;
  localparam logic [4:0] CharLim = (LimRaw > 31) ? 5'd31 : 5'(LimRaw);
  localparam logic [PosW-1:0] PosMax = PosW'(MAX_SENTENCE_LEN);

  // Input register
  logic       in_valid_q, in_valid_d;
  logic [7:0] in_char_q;

  // Parser state
  logic            open_q, open_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [1:0]      hm_q, hm_d;
  logic [4:0]      fc_q, fc_d;
  logic [4:0]      fcc_q, fcc_d;
  logic [7:0]      xor_q, xor_d;

  // Result register
  logic                 out_valid_q, out_valid_d;
  nmea_pkg::result_t    out_q, out_d;

  logic out_free;
  logic work;
  logic emit;
  logic typed;
  logic [7:0] c;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign work          = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;
  assign c             = in_char_q;

  // Input stage
  always_comb begin
    in_valid_d = in_valid_q;
    if (s_axis_tready) begin
      in_valid_d = s_axis_tvalid;
    end else if (work) begin
      in_valid_d = 1'b0;
    end
  end

  // Parse one character
  assign typed = (pos_q > PosW'(5)) && (hm_q == nmea_pkg::HmGga || hm_q == nmea_pkg::HmGsa);

  always_comb begin
    open_d = open_q;
    pos_d  = pos_q;
    hm_d   = hm_q;
    fc_d   = fc_q;
    fcc_d  = fcc_q;
    xor_d  = xor_q;
    emit   = 1'b0;
    out_d  = '0;
    out_d.sentence_type = (hm_q == nmea_pkg::HmGsa) ? nmea_pkg::TypeGsa : nmea_pkg::TypeGga;
    out_d.field_number  = fc_q;
    if (c == nmea_pkg::ChDollar) begin
      open_d = 1'b1;
      pos_d  = PosW'(1);
      hm_d   = nmea_pkg::HmSearch;
      fc_d   = '0;
      fcc_d  = '0;
      xor_d  = '0;
    end else if (!open_q) begin
      open_d = 1'b0;
    end else if (pos_q >= PosMax || c == nmea_pkg::ChCr || c == nmea_pkg::ChLf) begin
      open_d = 1'b0;
    end else if (c == nmea_pkg::ChStar) begin
      open_d         = 1'b0;
      emit           = typed;
      out_d.kind     = nmea_pkg::KindSum;
      out_d.checksum = xor_q;
    end else begin
      xor_d = xor_q ^ c;
      pos_d = pos_q + PosW'(1);
      // header match on bytes 1..5
      if (pos_q <= PosW'(5) && hm_q != nmea_pkg::HmNone) begin
        if (pos_q == PosW'(1) || pos_q == PosW'(3)) begin
          if (c != nmea_pkg::ChG) hm_d = nmea_pkg::HmNone;
        end else if (pos_q == PosW'(2)) begin
          if (c != nmea_pkg::ChP) hm_d = nmea_pkg::HmNone;
        end else if (pos_q == PosW'(4)) begin
          if (c == nmea_pkg::ChG) hm_d = nmea_pkg::HmGga;
          else if (c == nmea_pkg::ChS) hm_d = nmea_pkg::HmGsa;
          else hm_d = nmea_pkg::HmNone;
        end else begin
          if (c != nmea_pkg::ChA) hm_d = nmea_pkg::HmNone;
        end
      end
      if (c == nmea_pkg::ChComma) begin
        if (fc_q < 5'(nmea_pkg::FieldMax)) fc_d = fc_q + 5'd1;
        fcc_d = '0;
      end else begin
        if (fcc_q < CharLim) fcc_d = fcc_q + 5'd1;
        emit             = typed && nmea_pkg::field_wanted(hm_q, fc_q);
        out_d.kind       = nmea_pkg::KindChar;
        out_d.char_index = fcc_q;
        out_d.char_value = c;
      end
    end
  end

  // Output stage
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_free) begin
      out_valid_d = work && emit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      open_q      <= 1'b0;
      pos_q       <= '0;
      hm_q        <= nmea_pkg::HmSearch;
      fc_q        <= '0;
      fcc_q       <= '0;
      xor_q       <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (work) begin
        open_q <= open_d;
        pos_q  <= pos_d;
        hm_q   <= hm_d;
        fc_q   <= fc_d;
        fcc_q  <= fcc_d;
        xor_q  <= xor_d;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_char_q <= s_axis_tdata;
    end
    if (work && emit && out_free) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_q.checksum, out_q.char_value,
                          out_q.char_index, out_q.field_number};
  assign m_axis_tuser  = {out_q.sentence_type, out_q.kind};

  // Checks
  a_sum_fields_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.kind == nmea_pkg::KindSum) |->
      (out_q.char_value == 8'd0 && out_q.char_index == 5'd0))
    else $error("checksum result carries character fields");

  a_char_wanted : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.kind == nmea_pkg::KindChar) |->
      (out_q.checksum == 8'd0 && out_q.field_number != 5'd0 &&
       out_q.char_value != nmea_pkg::ChComma))
    else $error("field character result malformed");

  a_counts_bounded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fcc_q <= CharLim) && (pos_q <= PosMax))
    else $error("field or sentence counter out of range");

endmodule

/* verif/testbench.sv */
// Self-checking bench for nmea_gga_gsa_field_extractor: NMEA sentences in, field
// characters and checksums out, checked against a cycle-free parser model kept here.
// Depends on nmea_pkg and the extractor RTL.
`timescale 1ns / 1ps

module testbench;

  localparam int          ClkPeriod      = 12;
  localparam int unsigned SentenceLenMax = 256;
  localparam int unsigned FieldChars     = 20;
  localparam int unsigned CharIndexMax   = 19;   // FieldChars - 1, below 31
  localparam int          TargetChars    = 1220;
  localparam int          DrainCycles    = 20;

  typedef enum int {
    SnGga, SnGsa, SnLongField, SnManyFields, SnOverlong, SnUnknown, SnBroken, SnNoise,
    SnCount
  } sentence_kind_e;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;   // [7:0] rx_char
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;            // [4:0] field_number, [9:5] char_index,
                                        // [17:10] char_value, [25:18] checksum
  logic [1:0]  m_axis_tuser;            // [0] kind, [1] sentence_type

  // Characters waiting to be sent and results the parser model predicts
  logic [7:0]        pending_chars[$];
  nmea_pkg::result_t expected_results[$];

  // Parser model state
  logic        sn_open  = 1'b0;
  int unsigned sn_pos   = 0;
  logic [1:0]  hdr      = nmea_pkg::HmSearch;
  logic [4:0]  fld_cnt  = '0;
  logic [4:0]  chr_cnt  = '0;
  logic [7:0]  xor_acc  = '0;

  int error_count    = 0;
  int chars_accepted = 0;
  int results_seen   = 0;
  int sums_seen      = 0;
  int sentence_total = 0;

  // Long receiver hold-off
  int   hold_left = 0;
  int   hold_seen = 0;
  logic hold_done = 1'b0;

  nmea_gga_gsa_field_extractor #(
    .MAX_SENTENCE_LEN(SentenceLenMax),
    .MAX_FIELD_CHARS (FieldChars)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Parser model
  // ---------------------------------------------------------------------------

  function automatic logic field_of_interest(input logic [1:0] h, input logic [4:0] f);
    logic w;
    w = 1'b0;
    case (h)
      nmea_pkg::HmGga: w = (f >= 5'd1 && f <= 5'd5) || f == 5'd9 || f == 5'd10;
      nmea_pkg::HmGsa: w = (f >= 5'd3 && f <= 5'd10);
      default:         w = 1'b0;
    endcase
    return w;
  endfunction

  // Advance the model by one accepted character; queue any result it yields
  task automatic track_nmea_char(input logic [7:0] c);
    logic              typed;
    logic [4:0]        idx;
    nmea_pkg::result_t r;
    r = '0;
    if (c == nmea_pkg::ChDollar) begin
      sn_open = 1'b1;
      sn_pos  = 1;
      hdr     = nmea_pkg::HmSearch;
      fld_cnt = '0;
      chr_cnt = '0;
      xor_acc = '0;
    end else if (sn_open) begin
      if (sn_pos >= SentenceLenMax || c == nmea_pkg::ChCr || c == nmea_pkg::ChLf) begin
        sn_open = 1'b0;
      end else begin
        typed = (sn_pos > 5) && (hdr == nmea_pkg::HmGga || hdr == nmea_pkg::HmGsa);
        r.sentence_type = (hdr == nmea_pkg::HmGsa) ? nmea_pkg::TypeGsa : nmea_pkg::TypeGga;
        if (c == nmea_pkg::ChStar) begin
          sn_open = 1'b0;
          if (typed) begin
            r.kind         = nmea_pkg::KindSum;
            r.field_number = fld_cnt;
            r.checksum     = xor_acc;
            expected_results.push_back(r);
          end
        end else begin
          xor_acc = xor_acc ^ c;
          // header "GPGGA" / "GPGSA" match, first mismatch sticks
          if (sn_pos <= 5 && hdr != nmea_pkg::HmNone) begin
            case (sn_pos)
              1, 3: if (c != nmea_pkg::ChG) hdr = nmea_pkg::HmNone;
              2:    if (c != nmea_pkg::ChP) hdr = nmea_pkg::HmNone;
              4: begin
                if (c == nmea_pkg::ChG) hdr = nmea_pkg::HmGga;
                else if (c == nmea_pkg::ChS) hdr = nmea_pkg::HmGsa;
                else hdr = nmea_pkg::HmNone;
              end
              default: if (c != nmea_pkg::ChA) hdr = nmea_pkg::HmNone;
            endcase
          end
          sn_pos = sn_pos + 1;
          if (c == nmea_pkg::ChComma) begin
            if (fld_cnt < nmea_pkg::FieldMax) fld_cnt = fld_cnt + 1'b1;
            chr_cnt = '0;
          end else begin
            idx = chr_cnt;
            if (chr_cnt < CharIndexMax) chr_cnt = chr_cnt + 1'b1;
            if (typed && field_of_interest(hdr, fld_cnt)) begin
              r.kind         = nmea_pkg::KindChar;
              r.field_number = fld_cnt;
              r.char_index   = idx;
              r.char_value   = c;
              expected_results.push_back(r);
            end
          end
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sentence builders
  // ---------------------------------------------------------------------------

  function automatic logic is_special(input logic [7:0] b);
    return b == nmea_pkg::ChDollar || b == nmea_pkg::ChStar || b == nmea_pkg::ChComma ||
           b == nmea_pkg::ChCr || b == nmea_pkg::ChLf;
  endfunction

  function automatic logic [7:0] rand_plain_byte();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    while (is_special(b)) b = 8'($urandom_range(255));
    return b;
  endfunction

  // Mostly typical NMEA payload characters, sometimes any non-delimiter byte
  function automatic logic [7:0] rand_field_char();
    string alphabet;
    alphabet = "0123456789.NSEWM";
    if ($urandom_range(99) < 80) return alphabet[$urandom_range(alphabet.len() - 1)];
    return rand_plain_byte();
  endfunction

  task automatic push_byte(input logic [7:0] b);
    pending_chars.push_back(b);
  endtask

  task automatic push_str(input string s);
    for (int i = 0; i < s.len(); i++) pending_chars.push_back(s[i]);
  endtask

  task automatic push_chars(input int n);
    for (int i = 0; i < n; i++) push_byte(rand_field_char());
  endtask

  // Comma-separated fields of random length
  task automatic push_body(input int nfields, input int maxlen);
    for (int f = 0; f < nfields; f++) begin
      push_byte(nmea_pkg::ChComma);
      push_chars($urandom_range(maxlen));
    end
  endtask

  // '*', two hex digits (ignored, sentence already closed), then line end
  task automatic push_tail();
    string hex;
    hex = "0123456789ABCDEF";
    push_byte(nmea_pkg::ChStar);
    push_byte(hex[$urandom_range(15)]);
    push_byte(hex[$urandom_range(15)]);
    if ($urandom_range(3) != 0) push_byte(nmea_pkg::ChCr);
    push_byte(nmea_pkg::ChLf);
  endtask

  function automatic sentence_kind_e pick_kind();
    int r;
    r = $urandom_range(99);
    if (r < 35) return SnGga;
    if (r < 65) return SnGsa;
    if (r < 70) return SnLongField;
    if (r < 75) return SnManyFields;
    if (r < 77) return SnOverlong;
    if (r < 85) return SnUnknown;
    if (r < 93) return SnBroken;
    return SnNoise;
  endfunction

  task automatic add_sentence(input sentence_kind_e kind);
    string      hdr_s;
    int         at;
    logic [7:0] b;
    sentence_total++;
    case (kind)
      SnGga: begin
        push_str("$GPGGA");
        push_body(14, 7);
        push_tail();
      end
      SnGsa: begin
        push_str("$GPGSA");
        push_body(17, 3);
        push_tail();
      end
      // first field longer than the index saturation point
      SnLongField: begin
        push_str("$GPGGA,");
        push_chars($urandom_range(20, 30));
        push_body(9, 3);
        push_tail();
      end
      // more commas than the field counter can count
      SnManyFields: begin
        push_str("$GPGSA");
        push_body($urandom_range(33, 40), 2);
        push_tail();
      end
      // runs past the sentence length limit before any terminator
      SnOverlong: begin
        push_str("$GPGGA");
        for (int i = 0; i < 262; i++) begin
          if ($urandom_range(9) == 0) push_byte(nmea_pkg::ChComma);
          else push_byte(rand_field_char());
        end
        push_tail();
      end
      // one header byte corrupted so neither type matches
      SnUnknown: begin
        hdr_s = ($urandom_range(1) != 0) ? "GPGGA" : "GPGSA";
        at    = $urandom_range(4);
        b     = rand_plain_byte();
        while (b == hdr_s[at] || b == nmea_pkg::ChG || b == nmea_pkg::ChS)
          b = rand_plain_byte();
        push_byte(nmea_pkg::ChDollar);
        for (int i = 0; i < 5; i++) push_byte((i == at) ? b : hdr_s[i]);
        push_body(10, 3);
        push_tail();
      end
      SnBroken: begin
        case ($urandom_range(2))
          // terminator inside the header
          0: begin
            push_str("$GP");
            case ($urandom_range(2))
              0:       push_byte(nmea_pkg::ChStar);
              1:       push_byte(nmea_pkg::ChCr);
              default: push_byte(nmea_pkg::ChLf);
            endcase
          end
          // cut short, next '$' restarts
          1: begin
            push_str("$GPGGA,");
            push_chars($urandom_range(1, 6));
          end
          // closed by a line end, never reaches '*'
          default: begin
            push_str("$GPGSA");
            push_body(6, 3);
            push_byte(nmea_pkg::ChLf);
          end
        endcase
      end
      default: begin
        for (int i = 0; i < $urandom_range(1, 20); i++) push_byte(8'($urandom_range(255)));
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------

  initial begin : stim_proc
    int k;
    // idle bytes at the extremes, '$' restart inside a header, GSA field and sum
    push_byte(8'h00);
    push_byte(8'hFF);
    push_str("$G$GPGSA,,,7*");
    // star inside an unknown header
    push_str("$GX*");
    // GGA field closed by CR, no checksum
    push_str("$GPGGA,9");
    push_byte(nmea_pkg::ChCr);

    // every sentence kind once, then a weighted mix
    k = 0;
    while (pending_chars.size() < TargetChars) begin
      if (k < SnCount) add_sentence(sentence_kind_e'(k));
      else add_sentence(pick_kind());
      k++;
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_chars.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
      @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);

    $display("Sent %0d sentences and noise runs, %0d characters accepted.",
             sentence_total, chars_accepted);
    $display("Checked %0d results, %0d of them checksums.", results_seen, sums_seen);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin : timeout_proc
    #(ClkPeriod * 100000);
    $display("%0t: timeout, %0d results still expected", $time, expected_results.size());
    $display("DONE: errors detected");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Driver: one character per request, random gaps, a stretch with none
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin : drive_proc
    logic       nxt_valid;
    logic [7:0] nxt_data;
    logic       calm;
    if (rst_ni) begin
      nxt_valid = s_axis_tvalid;
      nxt_data  = s_axis_tdata;
      if (s_axis_tvalid && s_axis_tready) begin
        track_nmea_char(s_axis_tdata);
        chars_accepted++;
        nxt_valid = 1'b0;
      end
      calm = chars_accepted >= 600 && chars_accepted < 800;
      if (!nxt_valid && pending_chars.size() != 0 && (calm || $urandom_range(99) >= 32)) begin
        nxt_data  = pending_chars.pop_front();
        nxt_valid = 1'b1;
      end
      s_axis_tvalid <= nxt_valid;
      s_axis_tdata  <= nxt_data;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver hold-off: after some results, stall for a long stretch once
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin : hold_proc
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) hold_seen <= hold_seen + 1;
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
      end else if (!hold_done && hold_seen >= 120) begin
        hold_left <= 300;
        hold_done <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare each result request with the oldest prediction
  // ---------------------------------------------------------------------------

  task automatic compare_field(input string what, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      error_count++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, want, got);
    end
  endtask

  always @(posedge clk_i) begin : watch_proc
    nmea_pkg::result_t got;
    nmea_pkg::result_t want;
    logic              calm;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.field_number  = m_axis_tdata[4:0];
        got.char_index    = m_axis_tdata[9:5];
        got.char_value    = m_axis_tdata[17:10];
        got.checksum      = m_axis_tdata[25:18];
        got.kind          = m_axis_tuser[0];
        got.sentence_type = m_axis_tuser[1];
        results_seen++;
        if (got.kind == nmea_pkg::KindSum) sums_seen++;
        if (expected_results.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result, expected none, actual tdata 0x%08h tuser %b",
                   $time, m_axis_tdata, m_axis_tuser);
        end else begin
          want = expected_results.pop_front();
          compare_field("kind", want.kind, got.kind);
          compare_field("sentence_type", want.sentence_type, got.sentence_type);
          compare_field("field_number", want.field_number, got.field_number);
          compare_field("char_index", want.char_index, got.char_index);
          compare_field("char_value", want.char_value, got.char_value);
          compare_field("checksum", want.checksum, got.checksum);
          compare_field("tdata padding", 0, m_axis_tdata[31:26]);
        end
      end
      calm = results_seen >= 400 && results_seen < 550;
      m_axis_tready <= (hold_left == 0) && (calm || $urandom_range(99) >= 32);
    end
  end

endmodule

/* filelist.f */
hdl/nmea_pkg.sv
hdl/nmea_gga_gsa_field_extractor.sv
verif/testbench.sv
